FILE: src/assert_macros.svh
// Assertion helpers used by the stencil top level. Every check is sampled on clock and
// is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define STC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The expression must never be true at a sampled edge.
`define STC_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: src/stc_pkg.sv
// ----------------------------------------------------------------------------
// Stencil package
// Shared types, register indexes and fixed-point helpers of the stencil.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int TILE_DEF = 32;
   localparam int QW = 32;
   localparam int PW = 48;
   localparam int SW = 52;
   localparam int IW = 5;
   localparam int CSR_IW = 3;

   localparam logic [CSR_IW-1:0] CSR_DIFFUSION  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ADVECTION  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_PRESSURE   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DIVERGENCE = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_STREAM_X   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_STREAM_Y   = 3'd5;

   typedef struct packed {
      logic signed [QW-1:0] u;
      logic signed [QW-1:0] v;
      logic signed [QW-1:0] p;
   } cell_type;

   typedef struct packed {
      logic signed [QW-1:0] diffusion;
      logic signed [QW-1:0] advection;
      logic signed [QW-1:0] pressure;
      logic signed [QW-1:0] divergence;
      logic signed [QW-1:0] stream_x;
      logic signed [QW-1:0] stream_y;
   } coef_type;

   typedef struct packed {
      cell_type north;
      cell_type west;
      cell_type center;
      cell_type east;
      cell_type south;
      logic [IW-1:0] col;
      logic [IW-1:0] row;
      logic done;
   } stencil_type;

   function automatic logic signed [QW-1:0] sat32(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'(signed'({1'b0, {(QW-1){1'b1}}}));
      lo = SW'(signed'({1'b1, {(QW-1){1'b0}}}));
      if (x > hi) begin
         return hi[QW-1:0];
      end else if (x < lo) begin
         return lo[QW-1:0];
      end
      return x[QW-1:0];
   endfunction

   // Product of two Q16.16 values, returned as Q32.16 and rounded toward minus infinity.
   function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] prod;
      prod = a * b;
      return prod[2*QW-1:16];
   endfunction

endpackage

FILE: src/stc_window.sv
// ----------------------------------------------------------------------------
// Stencil window
// Tracks the padded position, keeps the two previous rows in a line memory
// and assembles the 5-point neighborhood of each interior cell.
// ----------------------------------------------------------------------------
module stc_window import stc_pkg::*; #(
   parameter int TILE = TILE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  cell_type    in_cell,
   output logic        out_valid,
   input  logic        out_ready,
   output stencil_type out_st
);

   localparam int PAD_W = TILE + 2;
   localparam int CW = $clog2(PAD_W);
   localparam int AW = $clog2(2 * PAD_W);

   cell_type mem [2*PAD_W];

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] east_col;
   logic [AW-1:0] cur_addr, mid_base, north_addr, east_addr;
   logic          accept;

   logic          v1_ff;
   cell_type      s1_ff;
   cell_type      n1_ff;
   cell_type      m1_ff;
   logic [CW-1:0] c1_ff;
   logic [CW-1:0] r1_ff;
   logic          rdy1;
   logic          take1;

   logic          v2_ff;
   logic          emit2_ff;
   logic          rdy2;
   cell_type      east_ff, center_ff, west_ff, south_ff, north_ff;
   logic [IW-1:0] col2_ff, row2_ff;
   logic          done2_ff;
   logic          emit1;
   logic [CW+IW-1:0] col_ix, row_ix;

   assign rdy2     = !v2_ff || !emit2_ff || out_ready;
   assign take1    = v1_ff && rdy2;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign accept   = in_valid && rdy1;

   // The first column of a row has no north neighbor to fetch, so that port
   // fetches the west end of the middle row instead.
   assign east_col   = (col_ff == CW'(PAD_W - 1)) ? col_ff : col_ff + 1'b1;
   assign cur_addr   = (row_ff[0] ? AW'(PAD_W) : '0) + AW'(col_ff);
   assign mid_base   = row_ff[0] ? '0 : AW'(PAD_W);
   assign north_addr = (col_ff == '0) ? mid_base : cur_addr;
   assign east_addr  = mid_base + AW'(east_col);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == CW'(PAD_W - 1)) begin
            col_in = '0;
            row_in = (row_ff == CW'(PAD_W - 1)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n1_ff         <= mem[north_addr];
         m1_ff         <= mem[east_addr];
         mem[cur_addr] <= in_cell;
         s1_ff         <= in_cell;
         c1_ff         <= col_ff;
         r1_ff         <= row_ff;
      end
   end

   // The center is directly above the newest cell.
   assign emit1  = (r1_ff >= CW'(2)) && (c1_ff >= CW'(1)) && (c1_ff <= CW'(TILE));
   assign col_ix = (CW+IW)'(c1_ff) - (CW+IW)'(1);
   assign row_ix = (CW+IW)'(r1_ff) - (CW+IW)'(2);

   always_ff @(posedge clock) begin
      if (take1) begin
         east_ff   <= m1_ff;
         center_ff <= (c1_ff == '0) ? n1_ff : east_ff;
         west_ff   <= center_ff;
         south_ff  <= s1_ff;
         north_ff  <= n1_ff;
         emit2_ff  <= emit1;
         col2_ff   <= col_ix[IW-1:0];
         row2_ff   <= row_ix[IW-1:0];
         done2_ff  <= (c1_ff == CW'(TILE)) && (r1_ff == CW'(TILE + 1));
      end
   end

   assign out_valid     = v2_ff && emit2_ff;
   assign out_st.north  = north_ff;
   assign out_st.west   = west_ff;
   assign out_st.center = center_ff;
   assign out_st.east   = east_ff;
   assign out_st.south  = south_ff;
   assign out_st.col    = col2_ff;
   assign out_st.row    = row2_ff;
   assign out_st.done   = done2_ff;

endmodule

FILE: src/stc_arith.sv
// ----------------------------------------------------------------------------
// Stencil arithmetic
// Five register stages: differences, products, advection sums, advection
// scaling and final saturation into the result register.
// ----------------------------------------------------------------------------
module stc_arith import stc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  stencil_type       in_st,
   input  coef_type          coef,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [IW-1:0]     out_col,
   output logic [IW-1:0]     out_row,
   output logic signed [QW-1:0] out_incr_x,
   output logic signed [QW-1:0] out_incr_y,
   output logic signed [QW-1:0] out_div,
   output logic              out_done
);

   localparam int NS = 5;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;
   logic [NS-1:0] ld;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
         ld[k]  = rdy[k] && ((k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k-1]);
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   logic [IW-1:0] col_ff [NS];
   logic [IW-1:0] row_ff [NS];
   logic          done_ff [NS];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (ld[k]) begin
            col_ff[k]  <= (k == 0) ? in_st.col  : col_ff[(k == 0) ? 0 : k-1];
            row_ff[k]  <= (k == 0) ? in_st.row  : row_ff[(k == 0) ? 0 : k-1];
            done_ff[k] <= (k == 0) ? in_st.done : done_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // Stage a: saturated sums and differences.
   logic signed [QW-1:0] lap_u_ff, lap_v_ff, ux_ff, vy_ff;
   logic signed [QW-1:0] dux_ff, duy_ff, dvx_ff, dvy_ff, dpx_ff, dpy_ff;
   logic signed [QW-1:0] cu_a_ff, cv_a_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         lap_u_ff <= sat32(SW'(in_st.east.u) + SW'(in_st.south.u) + SW'(in_st.west.u)
                           + SW'(in_st.north.u) - (SW'(in_st.center.u) <<< 2));
         lap_v_ff <= sat32(SW'(in_st.east.v) + SW'(in_st.south.v) + SW'(in_st.west.v)
                           + SW'(in_st.north.v) - (SW'(in_st.center.v) <<< 2));
         ux_ff    <= sat32(SW'(in_st.center.u) + SW'(coef.stream_x));
         vy_ff    <= sat32(SW'(in_st.center.v) + SW'(coef.stream_y));
         dux_ff   <= sat32(SW'(in_st.east.u) - SW'(in_st.west.u));
         duy_ff   <= sat32(SW'(in_st.south.u) - SW'(in_st.north.u));
         dvx_ff   <= sat32(SW'(in_st.east.v) - SW'(in_st.west.v));
         dvy_ff   <= sat32(SW'(in_st.south.v) - SW'(in_st.north.v));
         dpx_ff   <= sat32(SW'(in_st.east.p) - SW'(in_st.west.p));
         dpy_ff   <= sat32(SW'(in_st.south.p) - SW'(in_st.north.p));
         cu_a_ff  <= in_st.center.u;
         cv_a_ff  <= in_st.center.v;
      end
   end

   // Stage b: products.
   logic signed [PW-1:0] auxx_ff, avyx_ff, auxy_ff, avyy_ff;
   logic signed [PW-1:0] px_ff, py_ff, lx_ff, ly_ff;
   logic signed [QW-1:0] divsum_ff, cu_b_ff, cv_b_ff;

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         auxx_ff   <= mulq(ux_ff, dux_ff);
         avyx_ff   <= mulq(vy_ff, duy_ff);
         auxy_ff   <= mulq(ux_ff, dvx_ff);
         avyy_ff   <= mulq(vy_ff, dvy_ff);
         px_ff     <= mulq(coef.pressure, dpx_ff);
         py_ff     <= mulq(coef.pressure, dpy_ff);
         lx_ff     <= mulq(coef.diffusion, lap_u_ff);
         ly_ff     <= mulq(coef.diffusion, lap_v_ff);
         divsum_ff <= sat32(SW'(dux_ff) + SW'(dvy_ff));
         cu_b_ff   <= cu_a_ff;
         cv_b_ff   <= cv_a_ff;
      end
   end

   // Stage c: advection sums, partial results, divergence product.
   logic signed [QW-1:0] adv_u_ff, adv_v_ff;
   logic signed [SW-1:0] part_x_c_ff, part_y_c_ff;
   logic signed [PW-1:0] div_c_ff;

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         adv_u_ff    <= sat32(SW'(auxx_ff) + SW'(avyx_ff));
         adv_v_ff    <= sat32(SW'(auxy_ff) + SW'(avyy_ff));
         part_x_c_ff <= SW'(cu_b_ff) + SW'(px_ff) + SW'(lx_ff);
         part_y_c_ff <= SW'(cv_b_ff) + SW'(py_ff) + SW'(ly_ff);
         div_c_ff    <= mulq(coef.divergence, divsum_ff);
      end
   end

   // Stage d: advection scaling.
   logic signed [PW-1:0] ax_ff, ay_ff, div_d_ff;
   logic signed [SW-1:0] part_x_d_ff, part_y_d_ff;

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         ax_ff       <= mulq(coef.advection, adv_u_ff);
         ay_ff       <= mulq(coef.advection, adv_v_ff);
         part_x_d_ff <= part_x_c_ff;
         part_y_d_ff <= part_y_c_ff;
         div_d_ff    <= div_c_ff;
      end
   end

   // Stage e: result register.
   logic signed [QW-1:0] incr_x_ff, incr_y_ff, div_ff;

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         incr_x_ff <= sat32(part_x_d_ff + SW'(ax_ff));
         incr_y_ff <= sat32(part_y_d_ff + SW'(ay_ff));
         div_ff    <= sat32(SW'(div_d_ff));
      end
   end

   assign out_col    = col_ff[NS-1];
   assign out_row    = row_ff[NS-1];
   assign out_done   = done_ff[NS-1];
   assign out_incr_x = incr_x_ff;
   assign out_incr_y = incr_y_ff;
   assign out_div    = div_ff;

endmodule

FILE: src/advection_diffusion_pressure_stencil.sv
// A result passes through 2 register stages in the window and 5 in the arithmetic
// after the request that completes its neighborhood is accepted.
// Throughput: one request per cycle when no stall is raised, set by the two read
// ports of the line memory; every stage is handshaked, so a stall loses nothing.
// Reset (synchronous, active high) clears the position counters, the stage
// valid bits and the coefficient registers; the line memory is not cleared.
// ----------------------------------------------------------------------------
// Advection, diffusion and pressure stencil
// Raster tile in, per-cell velocity and divergence increments out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module advection_diffusion_pressure_stencil import stc_pkg::*; #(
   parameter int TILE = TILE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [QW-1:0] req_vel_x,
   input  logic signed [QW-1:0] req_vel_y,
   input  logic signed [QW-1:0] req_pressure,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IW-1:0]        rsp_cell_col,
   output logic [IW-1:0]        rsp_cell_row,
   output logic signed [QW-1:0] rsp_incr_x,
   output logic signed [QW-1:0] rsp_incr_y,
   output logic signed [QW-1:0] rsp_div_incr,
   output logic                 rsp_tile_done,
   input  logic                 csr_write,
   input  logic [CSR_IW-1:0]    csr_index,
   input  logic [QW-1:0]        csr_data
);

   coef_type    coef_ff, coef_in;
   cell_type    in_cell;
   stencil_type st;
   logic        st_valid;
   logic        st_ready;
   logic        in_ready;
   logic        last_cell;
   logic        done_out;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DIFFUSION:  coef_in.diffusion  = csr_data;
            CSR_ADVECTION:  coef_in.advection  = csr_data;
            CSR_PRESSURE:   coef_in.pressure   = csr_data;
            CSR_DIVERGENCE: coef_in.divergence = csr_data;
            CSR_STREAM_X:   coef_in.stream_x   = csr_data;
            CSR_STREAM_Y:   coef_in.stream_y   = csr_data;
            default:        coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign in_cell.u = req_vel_x;
   assign in_cell.v = req_vel_y;
   assign in_cell.p = req_pressure;
   assign req_stall = !in_ready;

   stc_window #(.TILE(TILE)) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_cell   (in_cell),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_st    (st)
   );

   stc_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (st_valid),
      .in_ready   (st_ready),
      .in_st      (st),
      .coef       (coef_ff),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_col    (rsp_cell_col),
      .out_row    (rsp_cell_row),
      .out_incr_x (rsp_incr_x),
      .out_incr_y (rsp_incr_y),
      .out_div    (rsp_div_incr),
      .out_done   (rsp_tile_done)
   );

   assign last_cell = rsp_cell_col == IW'(TILE - 1) && rsp_cell_row == IW'(TILE - 1);
   assign done_out  = rsp_valid && rsp_tile_done;

   `STC_ASSERT(a_done_last_cell, done_out |-> last_cell, "tile_done off the last cell")
   `STC_ASSERT(a_done_once, done_out && !rsp_stall |=> !done_out, "two tile_done results in a row")
   `STC_NEVER(a_result_without_request, rsp_valid && $past(reset), "result right after reset")

endmodule

FILE: bench/tb_advection_diffusion_pressure_stencil.sv
// ----------------------------------------------------------------------------
// Stencil block testbench
// Streams padded tiles of cells through the block with random gaps on the
// request side and random stalls on the result side. A behavioral model of
// the five-point arithmetic predicts each interior cell, and every result is
// compared field by field. Coefficients change between phases once the block
// has drained, covering zero, full-scale and random settings.
// ----------------------------------------------------------------------------
module tb_advection_diffusion_pressure_stencil;
   import stc_pkg::*;

   localparam int PAD = TILE_DEF + 2;
   localparam int PHASES = 8;
   localparam int PHASE_CELLS = 119;
   localparam int QUIET_CELLS = 60;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   typedef struct {
      logic [IW-1:0] col;
      logic [IW-1:0] row;
      logic [QW-1:0] incr_x;
      logic [QW-1:0] incr_y;
      logic [QW-1:0] div_incr;
      logic          done;
   } cell_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [QW-1:0] req_vel_x;
   logic signed [QW-1:0] req_vel_y;
   logic signed [QW-1:0] req_pressure;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [IW-1:0]        rsp_cell_col;
   logic [IW-1:0]        rsp_cell_row;
   logic signed [QW-1:0] rsp_incr_x;
   logic signed [QW-1:0] rsp_incr_y;
   logic signed [QW-1:0] rsp_div_incr;
   logic                 rsp_tile_done;
   logic                 csr_write;
   logic [CSR_IW-1:0]    csr_index;
   logic [QW-1:0]        csr_data;

   cell_result_type pending_results[$];
   longint          line_u[2*PAD];
   longint          line_v[2*PAD];
   longint          line_p[2*PAD];
   longint          coef[6];
   int              pad_col;
   int              pad_row;
   int              errors;
   bit              quiet;
   int              stall_left;

   logic [QW-1:0] edge_cells[25][3] = '{
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
      '{32'h80000000, 32'h80000000, 32'h80000000},
      '{32'h00000000, 32'h00000000, 32'h00000000},
      '{32'hffffffff, 32'hffffffff, 32'hffffffff},
      '{32'h00000001, 32'h00000001, 32'h00000001},
      '{32'h7fffffff, 32'h80000000, 32'h00000000},
      '{32'h80000000, 32'h7fffffff, 32'hffffffff},
      '{32'h55555555, 32'haaaaaaaa, 32'h55555555},
      '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa},
      '{32'h00010000, 32'hffff0000, 32'h00008000},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
      '{32'h80000000, 32'h80000000, 32'h80000000},
      '{32'h00000000, 32'h7fffffff, 32'h80000000},
      '{32'hffffffff, 32'h00000000, 32'h7fffffff},
      '{32'h00010000, 32'h00010000, 32'h00010000},
      '{32'hffff0000, 32'hffff0000, 32'hffff0000},
      '{32'h7fffffff, 32'h00000000, 32'h7fffffff},
      '{32'h80000000, 32'hffffffff, 32'h80000000},
      '{32'h0000ffff, 32'hffff0001, 32'h00000000},
      '{32'h12345678, 32'h87654321, 32'h0f0f0f0f},
      '{32'hf0f0f0f0, 32'h0f0f0f0f, 32'hf0f0f0f0},
      '{32'h7fffffff, 32'h7fffffff, 32'h80000000},
      '{32'h80000000, 32'h80000000, 32'h7fffffff},
      '{32'h00000000, 32'h00000000, 32'h00000000},
      '{32'hffffffff, 32'h7fffffff, 32'h00000001}
   };

   advection_diffusion_pressure_stencil dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(20 * 200000);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint clamp_q(input longint x);
      if (x > QMAX) return QMAX;
      if (x < QMIN) return QMIN;
      return x;
   endfunction

   function automatic longint scale_q(input longint a, input longint b);
      return (a * b) >>> 16;
   endfunction

   // Advances the padded position and predicts the result of the interior
   // cell whose neighborhood this request completes.
   function automatic void advance_stencil(input logic signed [QW-1:0] u,
                                           input logic signed [QW-1:0] v,
                                           input logic signed [QW-1:0] p);
      int cur_base, mid_base, c;
      longint nu, nv, np, wu, wv, wp, cu, cv, eu, ev, ep;
      longint lap_u, lap_v, ux, vy, dux, duy, dvx, dvy, dpx, dpy, adv_u, adv_v;
      cell_result_type res;
      c = pad_col;
      cur_base = (pad_row % 2) * PAD;
      mid_base = ((pad_row + 1) % 2) * PAD;
      if (pad_row >= 2 && c >= 1 && c <= TILE_DEF) begin
         nu = line_u[cur_base + c];    nv = line_v[cur_base + c];
         np = line_p[cur_base + c];
         wu = line_u[mid_base + c - 1]; wv = line_v[mid_base + c - 1];
         wp = line_p[mid_base + c - 1];
         cu = line_u[mid_base + c];    cv = line_v[mid_base + c];
         eu = line_u[mid_base + c + 1]; ev = line_v[mid_base + c + 1];
         ep = line_p[mid_base + c + 1];
         lap_u = clamp_q(eu + u + wu + nu - 4 * cu);
         lap_v = clamp_q(ev + v + wv + nv - 4 * cv);
         ux = clamp_q(cu + coef[CSR_STREAM_X]);
         vy = clamp_q(cv + coef[CSR_STREAM_Y]);
         dux = clamp_q(eu - wu);
         duy = clamp_q(u - nu);
         dvx = clamp_q(ev - wv);
         dvy = clamp_q(v - nv);
         dpx = clamp_q(ep - wp);
         dpy = clamp_q(p - np);
         adv_u = clamp_q(scale_q(ux, dux) + scale_q(vy, duy));
         adv_v = clamp_q(scale_q(ux, dvx) + scale_q(vy, dvy));
         res.col = IW'(c - 1);
         res.row = IW'(pad_row - 2);
         res.incr_x = QW'(clamp_q(cu + scale_q(coef[CSR_PRESSURE], dpx)
            + scale_q(coef[CSR_DIFFUSION], lap_u) + scale_q(coef[CSR_ADVECTION], adv_u)));
         res.incr_y = QW'(clamp_q(cv + scale_q(coef[CSR_PRESSURE], dpy)
            + scale_q(coef[CSR_DIFFUSION], lap_v) + scale_q(coef[CSR_ADVECTION], adv_v)));
         res.div_incr = QW'(clamp_q(scale_q(coef[CSR_DIVERGENCE], clamp_q(dux + dvy))));
         res.done = (c == TILE_DEF && pad_row == TILE_DEF + 1);
         pending_results.push_back(res);
      end
      line_u[cur_base + c] = u;
      line_v[cur_base + c] = v;
      line_p[cur_base + c] = p;
      if (c + 1 >= PAD) begin
         pad_col = 0;
         pad_row = (pad_row + 1 >= PAD) ? 0 : pad_row + 1;
      end else begin
         pad_col = c + 1;
      end
   endfunction

   function automatic logic [QW-1:0] random_q();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 32'h7fffffff;
      if (pick == 1) return 32'h80000000;
      if (pick < 4) return $urandom;
      return QW'($urandom_range(0, 2097152)) - 32'h00100000;
   endfunction

   task automatic send_cell(input logic [QW-1:0] u, input logic [QW-1:0] v,
                            input logic [QW-1:0] p);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_vel_x = u;
      req_vel_y = v;
      req_pressure = p;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      advance_stencil(u, v, p);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] index, input logic [QW-1:0] data);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = data;
      @(posedge clock);
      if (index <= CSR_STREAM_Y) coef[index] = longint'(signed'(data));
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic drain_block();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result col %0d row %0d", $time, rsp_cell_col,
               rsp_cell_row);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_cell_col !== want.col || rsp_cell_row !== want.row
                  || rsp_incr_x !== want.incr_x || rsp_incr_y !== want.incr_y
                  || rsp_div_incr !== want.div_incr || rsp_tile_done !== want.done) begin
               $display("%0t: expected col %0d row %0d x %h y %h div %h done %b", $time,
                  want.col, want.row, want.incr_x, want.incr_y, want.div_incr, want.done);
               $display("%0t: actual   col %0d row %0d x %h y %h div %h done %b", $time,
                  rsp_cell_col, rsp_cell_row, rsp_incr_x, rsp_incr_y, rsp_div_incr,
                  rsp_tile_done);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [QW-1:0] setting;
      int            cells;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_pressure = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      quiet = 1'b0;
      stall_left = 0;
      pad_col = 0;
      pad_row = 0;
      foreach (coef[i]) coef[i] = 0;
      foreach (line_u[i]) begin
         line_u[i] = 0;
         line_v[i] = 0;
         line_p[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain_block();
            for (int r = 0; r <= CSR_STREAM_Y; r++) begin
               case (phase)
                  2: setting = 32'h7fffffff;
                  4: setting = 32'h80000000;
                  5: setting = $urandom;
                  default: setting = QW'($urandom_range(0, 131072)) - 32'h00010000;
               endcase
               write_reg(r[CSR_IW-1:0], setting);
            end
            write_reg(phase % 2 ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         end
         cells = 0;
         if (phase == 0) begin
            foreach (edge_cells[i]) begin
               send_cell(edge_cells[i][0], edge_cells[i][1], edge_cells[i][2]);
               cells++;
            end
         end
         for (; cells < PHASE_CELLS; cells++) begin
            if (phase == PHASES - 1 && cells >= PHASE_CELLS - QUIET_CELLS) quiet = 1'b1;
            send_cell(random_q(), random_q(), random_q());
         end
      end
      drain_block();
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: advection_diffusion_pressure_stencil.f
+incdir+src
src/stc_pkg.sv
src/stc_window.sv
src/stc_arith.sv
src/advection_diffusion_pressure_stencil.sv
bench/tb_advection_diffusion_pressure_stencil.sv
